@@ src/assert_macros.svh @@
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property that must hold at every rising clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");
// expression that must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("%m: forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

@@ src/ihls_pkg.sv @@
// types, constants and step angle table for the rgb to ihls converter
package ihls_pkg;

  localparam int CORDIC_STEPS        = 16;
  localparam int ANGLE_FRACTION_BITS = 12;

  localparam int STEP_W     = $clog2(CORDIC_STEPS);
  localparam int VEC_SHIFT  = 14;
  localparam int SQRT3_Q14  = 28378;
  localparam int XY_W       = 28;
  localparam int ANG_W      = ANGLE_FRACTION_BITS + 11;
  localparam int ATAN_BITS  = 20;
  localparam int ATAN_LEN   = 24;

  localparam int COEF_R = 13894;
  localparam int COEF_G = 46858;
  localparam int COEF_B = 4719;

  localparam logic [7:0] GRAY_HUE_HALF = 8'd45;
  localparam logic [7:0] HUE_HALF_MAX  = 8'd179;

  localparam logic signed [ANG_W-1:0] THETA_180 =
    ANG_W'(180 * (1 << ANGLE_FRACTION_BITS));
  localparam logic signed [ANG_W-1:0] THETA_360 =
    ANG_W'(360 * (1 << ANGLE_FRACTION_BITS));

  // atan(2^-i) in degrees, q.20
  localparam longint ATAN_Q20 [ATAN_LEN] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
    234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
    917, 458, 229, 115, 57, 29, 14, 7
  };

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_pixel_t;

  typedef struct packed {
    logic [7:0] saturation;
    logic [7:0] luminance;
    logic [7:0] hue_half;
  } out_pixel_t;

  // item moving down the cordic chain with its side results
  typedef struct packed {
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [ANG_W-1:0] theta;
    logic                    gray;
    logic                    b_le_g;
    logic [7:0]              sat;
    logic [7:0]              lum;
  } cordic_t;

  // step angle rounded half up to the angle fraction
  function automatic logic signed [ANG_W-1:0] step_angle(input int i);
    longint t;
    int     sh;
    t  = ATAN_Q20[i];
    sh = ATAN_BITS - ANGLE_FRACTION_BITS;
    if (sh > 0) begin
      t = (t + (64'sd1 << (sh - 1))) >>> sh;
    end
    return ANG_W'(t);
  endfunction

endpackage

@@ src/rgb_to_ihls_pixel_core.sv @@
// top level of the rgb to ihls pixel converter
`include "assert_macros.svh"

// Converts one 8-bit rgb pixel per item into saturation (max minus min),
// luminance (0.212r + 0.715g + 0.072b in q0.16, truncated) and half hue
// (0..179, gray pixels give 45). The block takes one pixel every clock and
// gives one result every clock while the consumer does not stall; each item
// passes the front stage, one register per cordic rotation cell and the output
// stage. Every stage has its own valid bit and takes a new item whenever it
// is empty or its content moves on, so empty slots close up while the output
// is stalled and the input keeps flowing until the chain is full. No state
// carries over from one pixel to the next; reset only clears the valid bits.
module rgb_to_ihls_pixel_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ihls_pkg::in_pixel_t   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ihls_pkg::out_pixel_t  out_data
);

  localparam int N = ihls_pkg::CORDIC_STEPS;

  // chain links: link 0 leaves the front stage, link N enters the output stage
  logic [N:0]        link_valid;
  logic [N:0]        link_ready;
  ihls_pkg::cordic_t link_data [N+1];

  ihls_pre u_pre (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (link_valid[0]),
    .out_ready (link_ready[0]),
    .out_data  (link_data[0])
  );

  // one rotation cell per cordic step, step angle fixed per position
  for (genvar k = 0; k < N; k++) begin : g_cell
    ihls_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .step_idx  (ihls_pkg::STEP_W'(k)),
      .step_ang  (ihls_pkg::step_angle(k)),
      .in_valid  (link_valid[k]),
      .in_ready  (link_ready[k]),
      .in_data   (link_data[k]),
      .out_valid (link_valid[k+1]),
      .out_ready (link_ready[k+1]),
      .out_data  (link_data[k+1])
    );
  end

  // output register: holds a finished item while the consumer stalls
  ihls_post u_post (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (link_valid[N]),
    .in_ready  (link_ready[N]),
    .in_data   (link_data[N]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // an empty output stage lets ready run back through the whole chain
  `ASSERT_PROP(a_ready_when_drained, clk, rst_n, !out_valid |-> in_ready)
  // half hue never leaves its range
  `ASSERT_NEVER(a_hue_range, clk, rst_n, out_valid && (out_data.hue_half > 8'd179))
  // a pixel without saturation is gray and must show the gray hue
  `ASSERT_PROP(a_gray_hue, clk, rst_n,
    (out_valid && (out_data.saturation == 8'd0)) |-> (out_data.hue_half == 8'd45))
  // the weights sum just below one, so luminance tops out at 254
  `ASSERT_NEVER(a_lum_range, clk, rst_n, out_valid && (out_data.luminance == 8'd255))

endmodule

@@ src/ihls_pre.sv @@
// front stage: vector setup, saturation and luminance
module ihls_pre (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ihls_pkg::in_pixel_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ihls_pkg::cordic_t    out_data
);

  logic              valid_r;
  ihls_pkg::cordic_t data_r;
  ihls_pkg::cordic_t data_nxt;

  logic [7:0]                        mx, mn;
  logic signed [10:0]                dx;
  logic [7:0]                        dgb;
  logic [22:0]                       prod;
  logic [23:0]                       lsum;
  logic signed [ihls_pkg::XY_W-1:0]  x0, y0;

  always_comb begin
    mx = in_data.red;
    mn = in_data.red;
    if (in_data.green > mx) mx = in_data.green;
    if (in_data.blue  > mx) mx = in_data.blue;
    if (in_data.green < mn) mn = in_data.green;
    if (in_data.blue  < mn) mn = in_data.blue;

    lsum = 24'(16'(ihls_pkg::COEF_R) * 24'(in_data.red))
         + 24'(16'(ihls_pkg::COEF_G) * 24'(in_data.green))
         + 24'(16'(ihls_pkg::COEF_B) * 24'(in_data.blue));

    dx  = $signed({2'b00, in_data.red, 1'b0}) - $signed({3'b000, in_data.green})
        - $signed({3'b000, in_data.blue});
    dgb = (in_data.green >= in_data.blue) ? in_data.green - in_data.blue
                                          : in_data.blue - in_data.green;
    prod = 23'(dgb) * 23'(ihls_pkg::SQRT3_Q14);
    x0   = ihls_pkg::XY_W'(dx) <<< ihls_pkg::VEC_SHIFT;
    y0   = $signed(ihls_pkg::XY_W'(prod));

    data_nxt.sat    = mx - mn;
    data_nxt.lum    = lsum[23:16];
    data_nxt.gray   = (dx == 11'sd0) && (dgb == 8'd0);
    data_nxt.b_le_g = in_data.blue <= in_data.green;
    // left half-plane: mirror and start from 180 degrees
    if (x0 < 0) begin
      data_nxt.x     = -x0;
      data_nxt.y     = -y0;
      data_nxt.theta = ihls_pkg::THETA_180;
    end else begin
      data_nxt.x     = x0;
      data_nxt.y     = y0;
      data_nxt.theta = '0;
    end
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

@@ src/ihls_cell.sv @@
// one vectoring cordic rotation with its own stage register
module ihls_cell (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [ihls_pkg::STEP_W-1:0]         step_idx,
  input  logic signed [ihls_pkg::ANG_W-1:0]   step_ang,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  ihls_pkg::cordic_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output ihls_pkg::cordic_t                   out_data
);

  logic              valid_r;
  ihls_pkg::cordic_t data_r;
  ihls_pkg::cordic_t data_nxt;
  logic signed [ihls_pkg::XY_W-1:0] xs, ys;

  always_comb begin
    xs       = in_data.x >>> step_idx;
    ys       = in_data.y >>> step_idx;
    data_nxt = in_data;
    // rotate toward the x axis, both updates from the old vector
    if (!in_data.y[ihls_pkg::XY_W-1]) begin
      data_nxt.x     = in_data.x + ys;
      data_nxt.y     = in_data.y - xs;
      data_nxt.theta = in_data.theta + step_ang;
    end else begin
      data_nxt.x     = in_data.x - ys;
      data_nxt.y     = in_data.y + xs;
      data_nxt.theta = in_data.theta - step_ang;
    end
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

@@ src/ihls_post.sv @@
// output stage: angle clamp, hue folding and halving, gray hue and top clamp
module ihls_post (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ihls_pkg::cordic_t     in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ihls_pkg::out_pixel_t  out_data
);

  logic                              valid_r;
  ihls_pkg::out_pixel_t              data_r;
  ihls_pkg::out_pixel_t              data_nxt;
  logic signed [ihls_pkg::ANG_W-1:0] theta_c;
  logic signed [ihls_pkg::ANG_W-1:0] hue;
  logic signed [ihls_pkg::ANG_W-1:0] half;

  always_comb begin
    theta_c = in_data.theta;
    if (theta_c < 0) theta_c = '0;
    if (theta_c > ihls_pkg::THETA_180) theta_c = ihls_pkg::THETA_180;
    hue  = in_data.b_le_g ? theta_c : ihls_pkg::THETA_360 - theta_c;
    half = hue >>> (ihls_pkg::ANGLE_FRACTION_BITS + 1);

    data_nxt.saturation = in_data.sat;
    data_nxt.luminance  = in_data.lum;
    if (in_data.gray) begin
      data_nxt.hue_half = ihls_pkg::GRAY_HUE_HALF;
    end else if (half > $signed(ihls_pkg::ANG_W'(ihls_pkg::HUE_HALF_MAX))) begin
      data_nxt.hue_half = ihls_pkg::HUE_HALF_MAX;
    end else begin
      data_nxt.hue_half = half[7:0];
    end
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

@@ verif/ihls_result_checker.sv @@
// result checker for the rgb to ihls pixel converter: predicts each item and compares in order
module ihls_result_checker
  import ihls_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  in_pixel_t  in_data,
  input  logic       out_valid,
  input  logic       out_ready,
  input  out_pixel_t out_data,
  output int         errors,
  output int         pending,
  output int         checked,
  output int         gray_seen,
  output int         wrap_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;

  out_pixel_t expected_pixels[$];
  int         mismatch_count = 0;
  int         checked_count  = 0;
  int         gray_count     = 0;
  int         wrap_count     = 0;

  // bit-exact model of one pixel conversion
  function automatic out_pixel_t convert_pixel(input in_pixel_t px);
    longint     r, g, b, mx, mn, lum;
    longint     x, y, xs, ys, theta, hue, half, one, step;
    int         sh;
    out_pixel_t res;
    r  = px.red;
    g  = px.green;
    b  = px.blue;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    lum = (COEF_R * r + COEF_G * g + COEF_B * b) >>> 16;
    res.saturation = 8'(mx - mn);
    res.luminance  = 8'(lum);

    x     = (2 * r - g - b) * (64'sd1 <<< VEC_SHIFT);
    y     = ((g >= b) ? (g - b) : (b - g)) * SQRT3_Q14;
    one   = 64'sd1 <<< ANGLE_FRACTION_BITS;
    theta = 0;
    if (x == 0 && y == 0) begin
      res.hue_half = GRAY_HUE_HALF;
      return res;
    end
    if (x < 0) begin
      x     = -x;
      y     = -y;
      theta = 180 * one;
    end
    for (int i = 0; i < CORDIC_STEPS && i < ATAN_LEN; i++) begin
      xs   = x >>> i;
      ys   = y >>> i;
      step = ATAN_Q20[i];
      sh   = ATAN_BITS - ANGLE_FRACTION_BITS;
      if (sh > 0) step = (step + (64'sd1 <<< (sh - 1))) >>> sh;
      else if (sh < 0) step = step <<< (-sh);
      if (y >= 0) begin
        x     = x + ys;
        y     = y - xs;
        theta = theta + step;
      end else begin
        x     = x - ys;
        y     = y + xs;
        theta = theta - step;
      end
    end
    if (theta < 0) theta = 0;
    if (theta > 180 * one) theta = 180 * one;
    hue  = (b <= g) ? theta : 360 * one - theta;
    half = hue >>> (ANGLE_FRACTION_BITS + 1);
    if (half > HUE_HALF_MAX) half = HUE_HALF_MAX;
    res.hue_half = 8'(half);
    return res;
  endfunction

  always @(posedge clk) begin : watch
    out_pixel_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_pixels.push_back(convert_pixel(in_data));
      end
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: result with nothing expected: sat %0d lum %0d hue %0d",
                     $realtime, out_data.saturation, out_data.luminance,
                     out_data.hue_half);
        end else begin
          want = expected_pixels.pop_front();
          checked_count++;
          if (want.saturation == 8'd0 && want.hue_half == GRAY_HUE_HALF) gray_count++;
          if (want.hue_half == HUE_HALF_MAX) wrap_count++;
          if (out_data.saturation != want.saturation ||
              out_data.luminance  != want.luminance  ||
              out_data.hue_half   != want.hue_half) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
              $display("%0t: mismatch: expected sat %0d lum %0d hue %0d, got %0d %0d %0d",
                       $realtime, want.saturation, want.luminance, want.hue_half,
                       out_data.saturation, out_data.luminance, out_data.hue_half);
          end
        end
      end
    end
    errors    <= mismatch_count;
    pending   <= expected_pixels.size();
    checked   <= checked_count;
    gray_seen <= gray_count;
    wrap_seen <= wrap_count;
  end

endmodule

@@ verif/testbench.sv @@
// top level testbench for the rgb to ihls pixel converter: stimulus, handshake pacing, verdict
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ihls_pkg::*;

  // directed pixels, red in the top byte
  localparam int CORNER_COUNT = 22;
  localparam logic [23:0] CORNER_PIXELS [CORNER_COUNT] = '{
    24'h000000, 24'hffffff, 24'hff0000, 24'h00ff00, 24'h0000ff, 24'hffff00,
    24'h00ffff, 24'hff00ff, 24'h808080, 24'h010101, 24'hff0001, 24'hff0100,
    24'hfefeff, 24'hfefffe, 24'h00fffe, 24'h00feff, 24'h7f0080, 24'h807f7f,
    24'h55aa00, 24'h0080ff, 24'ha5a5a4, 24'h5a5a5b
  };
  localparam int RANDOM_COUNT = 1030;
  localparam int DRAIN_AT     = 520;   // sender waits for an empty pipeline here
  localparam int HOLD_AT      = 300;   // receiver holds off after this many results
  localparam int HOLD_CYCLES  = 80;    // well beyond the pipeline depth
  localparam int MAX_IDLE     = 13;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  in_pixel_t  in_data   = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_pixel_t out_data;

  int errors, pending, checked, gray_seen, wrap_seen;
  int pixels_sent = 0;
  int results_taken = 0;
  logic rx_holding = 1'b0;

  always #1 clk = ~clk;

  rgb_to_ihls_pixel_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  ihls_result_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .errors    (errors),
    .pending   (pending),
    .checked   (checked),
    .gray_seen (gray_seen),
    .wrap_seen (wrap_seen)
  );

  // component offset from a base, clamped to a byte
  function automatic logic [7:0] nudge(input int base, input int delta);
    int v;
    v = base + delta;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  // random pixel, biased toward gray, near-gray, extreme and tied components
  function automatic in_pixel_t random_pixel();
    in_pixel_t px;
    int        mode, base;
    logic [7:0] ends [4];
    ends = '{8'd0, 8'd1, 8'd254, 8'd255};
    mode = $urandom_range(0, 9);
    base = $urandom_range(0, 255);
    px   = in_pixel_t'(24'($urandom));
    case (mode)
      5, 6: begin
        // near gray, where the angle is most delicate
        px.red   = nudge(base, $urandom_range(0, 4) - 2);
        px.green = nudge(base, $urandom_range(0, 4) - 2);
        px.blue  = nudge(base, $urandom_range(0, 4) - 2);
      end
      7: begin
        px.red   = ends[$urandom_range(0, 3)];
        px.green = ends[$urandom_range(0, 3)];
        px.blue  = ends[$urandom_range(0, 3)];
      end
      8: begin
        // two components tied
        case ($urandom_range(0, 2))
          0: px.green = px.blue;
          1: px.red   = px.blue;
          default: px.red = px.green;
        endcase
      end
      9: begin
        // one component a step away from the other two
        px.red   = 8'(base);
        px.green = 8'(base);
        px.blue  = 8'(base);
        case ($urandom_range(0, 2))
          0: px.red   = nudge(base, $urandom_range(0, 1) ? 1 : -1);
          1: px.green = nudge(base, $urandom_range(0, 1) ? 1 : -1);
          default: px.blue = nudge(base, $urandom_range(0, 1) ? 1 : -1);
        endcase
      end
      default: ;
    endcase
    return px;
  endfunction

  // offer one item after an idle gap and hold it until accepted
  task automatic send_pixel(input in_pixel_t px, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pixels_sent++;
  endtask

  // sender gap: none while the receiver holds off or inside a burst stretch
  function automatic int sender_gap(input int n);
    if (rx_holding || (n / 150) % 4 == 3) return 0;
    return $urandom_range(0, MAX_IDLE);
  endfunction

  // stimulus
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < CORNER_COUNT; i++) begin
      send_pixel(in_pixel_t'(CORNER_PIXELS[i]), $urandom_range(0, 3));
    end

    for (int n = 0; n < RANDOM_COUNT; n++) begin
      if (n == DRAIN_AT) begin
        // let the pipeline empty before going on
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      send_pixel(random_pixel(), sender_gap(n));
    end
    in_valid <= 1'b0;

    // drain, then quiet for longer than the pipeline depth to catch stray results
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (CORDIC_STEPS + 8) @(posedge clk);

    $display("covered %0d pixels (%0d directed), %0d results checked", pixels_sent,
             CORNER_COUNT, checked);
    $display("%0d gray results, %0d at top hue, one long output stall, one full drain",
             gray_seen, wrap_seen);
    if (errors == 0 && pending == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // receiver: random stalls per item, burst stretches, and one long hold-off
  initial begin : receiver
    int  stall;
    bit  held;
    held = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && results_taken >= HOLD_AT) begin
        held = 1'b1;
        stall = HOLD_CYCLES;
        rx_holding <= 1'b1;
      end else if ((results_taken / 170) % 4 == 2) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, MAX_IDLE);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rx_holding <= 1'b0;
      out_ready  <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      results_taken++;
    end
  end

  // overall time limit, several times the slowest legal run
  initial begin
    #1_000_000;
    $display("timeout with %0d results still expected", pending);
    $display("testbench: errors");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/ihls_pkg.sv
src/ihls_pre.sv
src/ihls_cell.sv
src/ihls_post.sv
src/rgb_to_ihls_pixel_core.sv
verif/ihls_result_checker.sv
verif/testbench.sv
